// ===== src/rbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rbs_pkg;

  // Coordinate format: signed COORD_WIDTH-bit, FRAC_BITS fraction bits
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // Derived widths for the slab difference, the scaled numerator, the divider remainder and step counter
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int NUM_W  = COORD_WIDTH + FRAC_BITS + 1;
  localparam int REM_W  = COORD_WIDTH + 1;
  localparam int STEP_W = $clog2(NUM_W);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Axis codes
  localparam logic [1:0] AXIS_X       = 2'd0;
  localparam logic [1:0] AXIS_Z       = 2'd2;
  localparam logic [1:0] AXIS_IGNORED = 2'd3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [NUM_W-1:0]       num_t;

  // Saturation limits
  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [NUM_W-1:0] SAT_POS = NUM_W'(unsigned'(COORD_MAX));

  // Classified item handed from front to back
  typedef struct packed {
    logic   load;
    logic   last;
    logic   dir_zero;
    logic   in_slab;
    coord_t dir;
    diff_t  lo_diff;
    diff_t  hi_diff;
    coord_t t_begin;
    coord_t t_end;
  } rbs_cmd_t;

  // Divider request and response
  typedef struct packed {
    logic   start;
    num_t   num;
    coord_t den;
  } rbs_div_req_t;

  typedef struct packed {
    logic   done;
    coord_t quot;
  } rbs_div_rsp_t;

endpackage

`default_nettype wire

// ===== src/rbs_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rbs_in_if;
  import rbs_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] axis;
  coord_t     ray_origin;
  coord_t     ray_direction;
  coord_t     slab_low;
  coord_t     slab_high;
  coord_t     t_begin;
  coord_t     t_end;

  modport source (
    output valid, axis, ray_origin, ray_direction, slab_low, slab_high, t_begin, t_end,
    input  ready
  );

  modport sink (
    input  valid, axis, ray_origin, ray_direction, slab_low, slab_high, t_begin, t_end,
    output ready
  );

endinterface

`default_nettype wire

// ===== src/rbs_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rbs_out_if;

  logic valid;
  logic ready;
  logic hit;

  modport source (
    output valid, hit,
    input  ready
  );

  modport sink (
    input  valid, hit,
    output ready
  );

endinterface

`default_nettype wire

// ===== src/rbs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rbs_front (
  rbs_in_if.sink           item_in,
  output logic             push_valid,
  input  logic             push_ready,
  output rbs_pkg::rbs_cmd_t push_data
);
  import rbs_pkg::*;

  diff_t lo_diff;
  diff_t hi_diff;

  // Distances from the origin to both slab planes, exact at one extra bit
  assign lo_diff = diff_t'(item_in.slab_low)  - diff_t'(item_in.ray_origin);
  assign hi_diff = diff_t'(item_in.slab_high) - diff_t'(item_in.ray_origin);

  // Take every item while the queue has room; drop items on the unused axis code
  assign item_in.ready = push_ready;
  assign push_valid    = item_in.valid && (item_in.axis != AXIS_IGNORED);

  // Classify the item for the back end
  always_comb begin
    push_data.load     = (item_in.axis == AXIS_X);
    push_data.last     = (item_in.axis == AXIS_Z);
    push_data.dir_zero = (item_in.ray_direction == '0);
    // origin within the slab: low <= origin and origin <= high
    push_data.in_slab  = (lo_diff[DIFF_W-1] || (lo_diff == '0)) && !hi_diff[DIFF_W-1];
    push_data.dir      = item_in.ray_direction;
    push_data.lo_diff  = lo_diff;
    push_data.hi_diff  = hi_diff;
    push_data.t_begin  = item_in.t_begin;
    push_data.t_end    = item_in.t_end;
  end

endmodule

`default_nettype wire

// ===== src/rbs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rbs_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  rbs_pkg::rbs_cmd_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output rbs_pkg::rbs_cmd_t pop_data
);
  import rbs_pkg::*;

  rbs_cmd_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ===== src/rbs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rbs_div (
  input  logic                  clk,
  input  logic                  rst,
  input  rbs_pkg::rbs_div_req_t req,
  output rbs_pkg::rbs_div_rsp_t rsp
);
  import rbs_pkg::*;

  typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_FIX} div_state_t;

  div_state_t             state;
  logic [NUM_W-1:0]       shreg;
  logic [COORD_WIDTH-1:0] den_mag;
  logic [REM_W-1:0]       rem;
  logic                   neg;
  logic [STEP_W-1:0]      step;
  logic                   done;
  coord_t                 quot;

  logic [NUM_W-1:0]       num_abs;
  logic [COORD_WIDTH-1:0] den_abs;
  logic [REM_W-1:0]       rem_sh;
  logic [REM_W-1:0]       rem_sub;
  logic                   fits;
  coord_t                 quot_sat;

  // Magnitudes, one restoring step, and the signed saturated quotient
  always_comb begin
    num_abs = req.num[NUM_W-1] ? -req.num : req.num;
    den_abs = req.den[COORD_WIDTH-1] ? -req.den : req.den;
    rem_sh  = {rem[COORD_WIDTH-1:0], shreg[NUM_W-1]};
    fits    = (rem_sh >= {1'b0, den_mag});
    rem_sub = rem_sh - {1'b0, den_mag};
    if (neg) begin
      quot_sat = (shreg > SAT_POS) ? COORD_MIN : -shreg[COORD_WIDTH-1:0];
    end else begin
      quot_sat = (shreg > SAT_POS) ? COORD_MAX : shreg[COORD_WIDTH-1:0];
    end
  end

  // Sequencer: load, one quotient bit per cycle, then sign and saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        DIV_IDLE: begin
          if (req.start) begin
            shreg   <= num_abs;
            den_mag <= den_abs;
            neg     <= req.num[NUM_W-1] ^ req.den[COORD_WIDTH-1];
            rem     <= '0;
            step    <= STEP_W'(NUM_W - 1);
            state   <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          rem   <= fits ? rem_sub : rem_sh;
          shreg <= {shreg[NUM_W-2:0], fits};
          step  <= step - 1'b1;
          if (step == '0) state <= DIV_FIX;
        end
        DIV_FIX: begin
          quot  <= quot_sat;
          done  <= 1'b1;
          state <= DIV_IDLE;
        end
        default: state <= DIV_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (state == DIV_IDLE))
    else $error("divider started while busy");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == DIV_RUN) |-> (rem < {1'b0, den_mag}))
    else $error("partial remainder not below divisor");

  a_fix_done: assert property (@(posedge clk) disable iff (rst)
    (state == DIV_FIX) |=> (done && (state == DIV_IDLE)))
    else $error("quotient not delivered after fix-up");

endmodule

`default_nettype wire

// ===== src/rbs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rbs_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  rbs_pkg::rbs_cmd_t     pop_data,
  output rbs_pkg::rbs_div_req_t lo_req,
  output rbs_pkg::rbs_div_req_t hi_req,
  input  rbs_pkg::rbs_div_rsp_t lo_rsp,
  input  rbs_pkg::rbs_div_rsp_t hi_rsp,
  rbs_out_if.source             result_out
);
  import rbs_pkg::*;

  typedef enum logic [1:0] {BK_IDLE, BK_WAIT, BK_APPLY} back_state_t;

  back_state_t state;
  rbs_cmd_t    cmd;
  coord_t      running_begin;
  coord_t      running_end;
  logic        out_valid;
  logic        out_hit;

  coord_t base_begin;
  coord_t base_end;
  coord_t t0;
  coord_t t1;
  coord_t begin_next;
  coord_t end_next;
  logic   hit_next;
  logic   can_apply;
  logic   issue;

  assign pop_ready = (state == BK_IDLE);
  assign issue     = pop_ready && pop_valid && !pop_data.dir_zero;

  // Start both slab divisions as an item with nonzero direction leaves the queue
  always_comb begin
    lo_req.start = issue;
    lo_req.num   = num_t'(pop_data.lo_diff) <<< FRAC_BITS;
    lo_req.den   = pop_data.dir;
    hi_req.start = issue;
    hi_req.num   = num_t'(pop_data.hi_diff) <<< FRAC_BITS;
    hi_req.den   = pop_data.dir;
  end

  // Narrow the interval; axis x starts from the given interval
  always_comb begin
    base_begin = cmd.load ? cmd.t_begin : running_begin;
    base_end   = cmd.load ? cmd.t_end   : running_end;
    t0 = cmd.dir[COORD_WIDTH-1] ? hi_rsp.quot : lo_rsp.quot;
    t1 = cmd.dir[COORD_WIDTH-1] ? lo_rsp.quot : hi_rsp.quot;
    if (cmd.dir_zero) begin
      begin_next = base_begin;
      end_next   = cmd.in_slab ? base_end : base_begin;
    end else begin
      begin_next = (t0 > base_begin) ? t0 : base_begin;
      end_next   = (t1 < base_end)   ? t1 : base_end;
    end
    hit_next  = (end_next > begin_next);
    can_apply = !cmd.last || !out_valid || result_out.ready;
  end

  // Sequencer with the interval and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      out_valid     <= 1'b0;
      running_begin <= '0;
      running_end   <= '0;
    end else begin
      if (result_out.ready) out_valid <= 1'b0;
      unique case (state)
        BK_IDLE: begin
          if (pop_valid) begin
            cmd   <= pop_data;
            state <= pop_data.dir_zero ? BK_APPLY : BK_WAIT;
          end
        end
        BK_WAIT: begin
          if (lo_rsp.done) state <= BK_APPLY;
        end
        BK_APPLY: begin
          if (can_apply) begin
            running_begin <= begin_next;
            running_end   <= end_next;
            if (cmd.last) begin
              out_valid <= 1'b1;
              out_hit   <= hit_next;
            end
            state <= BK_IDLE;
          end
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.hit   = out_hit;

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    lo_rsp.done |-> hi_rsp.done)
    else $error("slab dividers out of step");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    (state != BK_WAIT) |-> !lo_rsp.done)
    else $error("quotient arrived while not waiting");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ((state == BK_APPLY) && cmd.last && out_valid && !result_out.ready)
      |=> (state == BK_APPLY))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== src/ray_box_slab_test.sv =====
// Coordinates are Q16.16. Each axis item passes the queue, then both slab dividers, then
// the interval update; items with zero direction skip the dividers. The back end takes one
// item at a time; the bit-serial dividers give one quotient bit per cycle, both planes in parallel.
// A two-entry queue lets the next item be taken while the back end works.
// Reset (rst, synchronous, active high) empties the queue, idles both dividers,
// drops any pending result and sets the stored interval to [0, 0].
`timescale 1ns / 1ps
`default_nettype none

module ray_box_slab_test (
  input  logic       clk,
  input  logic       rst,
  rbs_in_if.sink     item_in,
  rbs_out_if.source  result_out
);
  import rbs_pkg::*;

  logic         push_valid;
  logic         push_ready;
  rbs_cmd_t     push_data;
  logic         pop_valid;
  logic         pop_ready;
  rbs_cmd_t     pop_data;
  rbs_div_req_t lo_req;
  rbs_div_req_t hi_req;
  rbs_div_rsp_t lo_rsp;
  rbs_div_rsp_t hi_rsp;

  // Classify incoming items
  rbs_front u_front (
    .item_in    (item_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouple front and back
  rbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Slab parameter dividers, lower and upper plane
  rbs_div u_div_lo (
    .clk (clk),
    .rst (rst),
    .req (lo_req),
    .rsp (lo_rsp)
  );

  rbs_div u_div_hi (
    .clk (clk),
    .rst (rst),
    .req (hi_req),
    .rsp (hi_rsp)
  );

  // Narrow the interval and report
  rbs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .lo_req     (lo_req),
    .hi_req     (hi_req),
    .lo_rsp     (lo_rsp),
    .hi_rsp     (hi_rsp),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

// ===== sim/slab_hit_checker.sv =====
`timescale 1ns / 1ps

module slab_hit_checker (
  input  logic clk,
  input  logic rst,
  rbs_in_if    item_in,
  rbs_out_if   result_out,
  output int   mismatches,
  output int   outstanding
);
  import rbs_pkg::*;

  // Running parameter interval, narrowed one axis at a time
  coord_t run_begin;
  coord_t run_end;
  logic   expected_hits[$];
  int     fail_tally;

  // Scale the offset to the bound, divide by the direction, truncate and saturate
  function automatic coord_t slab_param(coord_t bound, coord_t origin, coord_t dir);
    longint num;
    longint quo;
    num = (longint'(bound) - longint'(origin)) * (longint'(1) <<< FRAC_BITS);
    quo = num / longint'(dir);
    if (quo > longint'(COORD_MAX)) quo = longint'(COORD_MAX);
    if (quo < longint'(COORD_MIN)) quo = longint'(COORD_MIN);
    return coord_t'(quo);
  endfunction

  always @(posedge clk) begin : watch_channels
    coord_t t_near;
    coord_t t_far;
    coord_t t_swap;
    logic   want_hit;
    if (rst) begin
      run_begin = '0;
      run_end = '0;
      expected_hits.delete();
      fail_tally = 0;
    end else begin
      // Compare each delivered result with the oldest prediction
      if (result_out.valid && result_out.ready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual hit=%0b",
                   $time, result_out.hit);
          fail_tally++;
        end else begin
          want_hit = expected_hits.pop_front();
          if (result_out.hit !== want_hit) begin
            $display("%0t: hit mismatch, expected %0b, actual %0b",
                     $time, want_hit, result_out.hit);
            fail_tally++;
          end
        end
      end

      // Narrow the interval for every accepted item on a real axis
      if (item_in.valid && item_in.ready && item_in.axis != AXIS_IGNORED) begin
        if (item_in.axis == AXIS_X) begin
          run_begin = item_in.t_begin;
          run_end = item_in.t_end;
        end
        if (item_in.ray_direction == '0) begin
          // Parallel ray: outside the slab empties the interval
          if (!(item_in.slab_low <= item_in.ray_origin &&
                item_in.ray_origin <= item_in.slab_high))
            run_end = run_begin;
        end else begin
          t_near = slab_param(item_in.slab_low, item_in.ray_origin, item_in.ray_direction);
          t_far = slab_param(item_in.slab_high, item_in.ray_origin, item_in.ray_direction);
          if (item_in.ray_direction < 0) begin
            t_swap = t_near;
            t_near = t_far;
            t_far = t_swap;
          end
          if (t_near > run_begin) run_begin = t_near;
          if (t_far < run_end) run_end = t_far;
        end
        if (item_in.axis == AXIS_Z)
          expected_hits.push_back(run_end > run_begin);
      end
    end
    mismatches <= fail_tally;
    outstanding <= expected_hits.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rbs_pkg::*;

  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam coord_t     ONE = coord_t'(1 << FRAC_BITS);
  localparam int         ITEM_TARGET = 1950;
  localparam int         TAIL_CYCLES = 2 * (NUM_W + 4) + 40;
  localparam int         CYCLE_LIMIT = 1_000_000;

  logic clk;
  logic rst;
  int   cycles = 0;
  int   burst_left = 0;
  int   sent = 0;
  int   rx_cycle = 0;
  int   rx_stall = 0;
  int   mismatches;
  int   outstanding;

  logic [1:0] axis_seq [3] = '{AXIS_X, AXIS_Y, AXIS_Z};

  rbs_in_if  item_if ();
  rbs_out_if result_if ();

  ray_box_slab_test uut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_if),
    .result_out (result_if)
  );

  slab_hit_checker chk (
    .clk         (clk),
    .rst         (rst),
    .item_in     (item_if),
    .result_out  (result_if),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Give up after a generous number of cycles
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: free-flowing windows alternate with windows of random stalls
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      result_if.ready <= (rx_stall == 1);
    end else if (rx_cycle[9] && $urandom_range(0, 5) == 0) begin
      rx_stall <= $urandom_range(1, 24);
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // Value anywhere in the range, biased towards the extremes
  function automatic coord_t any_coord();
    case ($urandom_range(0, 9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3:       return coord_t'(1);
      4:       return coord_t'(-1);
      5, 6:    return coord_t'(int'($urandom_range(0, 64 << FRAC_BITS)) - (32 << FRAC_BITS));
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Value within plus or minus span whole units
  function automatic coord_t near_coord(int span);
    return coord_t'(int'($urandom_range(0, (2 * span) << FRAC_BITS)) - (span << FRAC_BITS));
  endfunction

  // Drive one item and hold it until taken; idle between bursts
  task automatic send_item(input logic [1:0] ax, input coord_t org, input coord_t dir,
                           input coord_t lo, input coord_t hi,
                           input coord_t t_from, input coord_t t_to);
    int gap;
    if (burst_left == 0) begin
      gap = (cycles[11:10] == 2'b11 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    item_if.valid         <= 1'b1;
    item_if.axis          <= ax;
    item_if.ray_origin    <= org;
    item_if.ray_direction <= dir;
    item_if.slab_low      <= lo;
    item_if.slab_high     <= hi;
    item_if.t_begin       <= t_from;
    item_if.t_end         <= t_to;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    if (ax != AXIS_IGNORED) sent++;
  endtask

  // Well-formed test: three axes in order with plausible geometry
  task automatic send_ray();
    coord_t t_from;
    coord_t t_to;
    coord_t org;
    coord_t dir;
    coord_t lo;
    coord_t hi;
    coord_t tmp;
    case ($urandom_range(0, 5))
      0:       t_from = near_coord(4);
      1:       t_from = any_coord();
      default: t_from = '0;
    endcase
    case ($urandom_range(0, 5))
      0:       t_to = COORD_MAX;
      1:       t_to = any_coord();
      default: t_to = 64 * ONE;
    endcase
    for (int a = 0; a < 3; a++) begin
      org = near_coord(8);
      case ($urandom_range(0, 19))
        0:       dir = '0;
        1:       dir = any_coord();
        default: dir = near_coord(2);
      endcase
      lo = near_coord(16);
      hi = lo + coord_t'($urandom_range(0, 8 << FRAC_BITS));
      case ($urandom_range(0, 19))
        0: begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
        1: begin
          lo = any_coord();
          hi = any_coord();
        end
        default: ;
      endcase
      send_item(axis_seq[a], org, dir, lo, hi, t_from, t_to);
    end
  endtask

  initial begin
    rst = 1'b1;
    item_if.valid = 1'b0;
    item_if.axis = AXIS_X;
    item_if.ray_origin = '0;
    item_if.ray_direction = '0;
    item_if.slab_low = '0;
    item_if.slab_high = '0;
    item_if.t_begin = '0;
    item_if.t_end = '0;
    result_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // No axis 0 yet: narrow the reset interval, which is empty
    send_item(AXIS_Y, '0, ONE, ONE, 2 * ONE, '0, '0);
    send_item(AXIS_Z, '0, ONE, ONE, 2 * ONE, '0, '0);

    // Plain hit on all three axes
    send_item(AXIS_X, '0, ONE, ONE, 3 * ONE, '0, 10 * ONE);
    send_item(AXIS_Y, '0, ONE, ONE, 3 * ONE, 5 * ONE, 7 * ONE);
    send_item(AXIS_Z, '0, ONE, ONE, 3 * ONE, '0, '0);

    // Negative directions and a parallel ray inside its slab
    send_item(AXIS_X, '0, -ONE, -3 * ONE, -ONE, '0, 10 * ONE);
    send_item(AXIS_Y, '0, '0, -ONE, ONE, '0, '0);
    send_item(AXIS_Z, '0, -2 * ONE, -4 * ONE, -2 * ONE, '0, '0);

    // Parallel ray outside its slab misses
    send_item(AXIS_X, '0, ONE, ONE, 3 * ONE, '0, 10 * ONE);
    send_item(AXIS_Y, 5 * ONE, '0, '0, ONE, '0, '0);
    send_item(AXIS_Z, '0, ONE, ONE, 3 * ONE, '0, '0);

    // Extremes and saturated quotients, with an ignored item in the middle
    send_item(AXIS_X, COORD_MIN, coord_t'(1), COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX);
    send_item(AXIS_Y, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, '0, '0);
    send_item(AXIS_IGNORED, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
              COORD_MAX);
    send_item(AXIS_Z, '0, coord_t'(-1), COORD_MIN, COORD_MAX, '0, '0);

    // Inverted slab on the first axis
    send_item(AXIS_X, '0, ONE, 3 * ONE, ONE, '0, 10 * ONE);
    send_item(AXIS_Y, '0, ONE, ONE, 3 * ONE, '0, '0);
    send_item(AXIS_Z, '0, ONE, ONE, 3 * ONE, '0, '0);

    // Starting interval already reversed
    send_item(AXIS_X, '0, ONE, ONE, 3 * ONE, 10 * ONE, '0);
    send_item(AXIS_Y, '0, ONE, ONE, 3 * ONE, '0, '0);
    send_item(AXIS_Z, '0, ONE, ONE, 3 * ONE, '0, '0);

    // Mostly well-formed tests, some wild ones, broken sequences and noise
    while (sent < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          for (int a = 0; a < 3; a++)
            send_item(axis_seq[a], any_coord(), any_coord(), any_coord(), any_coord(),
                      any_coord(), any_coord());
        end
        2: begin
          repeat ($urandom_range(1, 4))
            send_item(2'($urandom_range(0, 3)), any_coord(), any_coord(), any_coord(),
                      any_coord(), any_coord(), any_coord());
        end
        3: send_item(AXIS_IGNORED, any_coord(), any_coord(), any_coord(), any_coord(),
                     any_coord(), any_coord());
        default: send_ray();
      endcase
    end
    item_if.valid <= 1'b0;

    // Drain the remaining results, then allow for anything stray
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
